[rtl/utd_pkg.sv]
// Package for the UTF-8 to UCS-2 decoder: constants, decoder state and result types,
// and the helper that gives how many bytes a long lead swallows. No dependencies.
package utd_pkg;

    localparam logic [7:0]  C_CONT_BASE  = 8'h80;
    localparam logic [7:0]  C_LEAD2_BASE = 8'hC0;
    localparam logic [7:0]  C_LEAD3_BASE = 8'hE0;
    localparam logic [7:0]  C_LEAD4_BASE = 8'hF0;
    localparam logic [7:0]  C_LEAD5_BASE = 8'hF8;
    localparam logic [7:0]  C_LEAD6_BASE = 8'hFC;
    localparam logic [15:0] C_LONG_CODE  = 16'h2000;

    localparam logic [1:0] C_HELD_NONE        = 2'd0;
    localparam logic [1:0] C_HELD_LEAD        = 2'd1;
    localparam logic [1:0] C_HELD_LEAD_FOLLOW = 2'd2;

    localparam logic [2:0] C_SKIP_MAX = 3'd5;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] held_byte;
        logic [1:0] held_count;
        logic [2:0] skip_remaining;
    } t_dec_state;

    typedef struct packed {
        logic        valid;
        logic [15:0] code_unit;
    } t_dec_result;

    function automatic logic [2:0] long_skip(input logic [7:0] b);
        logic [2:0] n;
        if (b >= C_LEAD6_BASE) begin
            n = 3'd5;
        end else if (b >= C_LEAD5_BASE) begin
            n = 3'd4;
        end else begin
            n = 3'd3;
        end
        return n;
    endfunction

endpackage

[rtl/utd_if.sv]
// Handshake channels of the decoder: the byte input and the code unit output.
// Depends on nothing.
interface utd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface utd_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

[rtl/utd_to_ucs2_decoder_core.sv]
// Top level of the UTF-8 to UCS-2 decoder: input register, decoder state and result register.
// Depends on utd_pkg, utd_if and utd_step.
//
// The decoder takes one byte per clock cycle while the output is not stalled, and gives at
// most one 16-bit code unit per byte. A byte waits in the input register and is decoded on
// its way into the result register; it waits while the result register holds an untaken
// unit. The decoder state is updated once per byte by a single pass of combinational logic,
// which sets that rate; bytes that complete no code unit give no result.
module utf8_to_ucs2_decoder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    utd_byte_if.sink        i_in,
    utd_unit_if.source      o_out
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eos;
    logic                 n_in_valid;
    utd_pkg::t_dec_state  r_state;
    utd_pkg::t_dec_state  n_state;
    logic                 r_out_valid;
    logic [15:0]          r_out_code;
    logic                 n_out_valid;

    utd_pkg::t_dec_state  step_state;
    utd_pkg::t_dec_result step_result;
    logic                 out_free;
    logic                 advance;
    logic                 in_take;

    utd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_eos    (r_in_eos),
        .o_state  (step_state),
        .o_result (step_result)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready     = !r_in_valid || advance;
    assign o_out.valid    = r_out_valid;
    assign o_out.code_unit = r_out_code;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_in_valid = 1'b0;
            n_state    = step_state;
        end
        if (in_take) begin
            n_in_valid = 1'b1;
        end
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (advance && step_result.valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.data_byte;
            r_in_eos  <= i_in.end_of_stream;
        end
        if (advance && step_result.valid) begin
            r_out_code <= step_result.code_unit;
        end
    end

    a_skip_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip_remaining <= utd_pkg::C_SKIP_MAX)
        else $error("Swallow count exceeds the longest sequence.");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held_count != 2'd3)
        else $error("Held count reached an unused code.");

    a_skip_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip_remaining != 3'd0 |-> r_state.held_count == utd_pkg::C_HELD_NONE)
        else $error("Bytes are held while a long sequence is being swallowed.");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_eos |=>
            r_state.held_count == utd_pkg::C_HELD_NONE && r_state.skip_remaining == 3'd0)
        else $error("Decoder state not cleared after the final item.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !advance)
        else $error("Result register overwritten while its item waits.");

endmodule

[rtl/utd_step.sv]
// Combinational decode of one byte against the current decoder state.
// Gives the next state and at most one code unit. Depends on utd_pkg.
module utd_step (
    input  utd_pkg::t_dec_state  i_state,
    input  logic [7:0]           i_byte,
    input  logic                 i_eos,
    output utd_pkg::t_dec_state  o_state,
    output utd_pkg::t_dec_result o_result
);

    utd_pkg::t_dec_state  nxt;
    utd_pkg::t_dec_result res;
    logic                 follow_ok;

    assign follow_ok = i_byte[7];

    always_comb begin
        nxt = i_state;
        res = '0;
        if (i_state.skip_remaining != 3'd0) begin
            nxt.skip_remaining = i_state.skip_remaining - 3'd1;
        end else begin
            case (i_state.held_count)
                utd_pkg::C_HELD_LEAD: begin
                    nxt.held_count = utd_pkg::C_HELD_NONE;
                    if (!follow_ok) begin
                        res.valid     = 1'b1;
                        res.code_unit = {8'h00, i_byte};
                    end else if (i_state.lead_byte < utd_pkg::C_LEAD3_BASE) begin
                        res.valid     = 1'b1;
                        res.code_unit = {5'b0, i_state.lead_byte[4:0], i_byte[5:0]};
                    end else begin
                        nxt.held_byte  = i_byte;
                        nxt.held_count = utd_pkg::C_HELD_LEAD_FOLLOW;
                    end
                end
                utd_pkg::C_HELD_LEAD_FOLLOW: begin
                    nxt.held_count = utd_pkg::C_HELD_NONE;
                    res.valid      = 1'b1;
                    if (follow_ok) begin
                        res.code_unit = {i_state.lead_byte[3:0], i_state.held_byte[5:0],
                                         i_byte[5:0]};
                    end else if (i_state.held_byte >= utd_pkg::C_LEAD4_BASE) begin
                        nxt.skip_remaining = utd_pkg::long_skip(i_state.held_byte) - 3'd1;
                        res.code_unit      = utd_pkg::C_LONG_CODE;
                    end else begin
                        res.code_unit = {8'h00, i_byte};
                    end
                end
                default: begin
                    nxt.held_count = utd_pkg::C_HELD_NONE;
                    if (i_byte < utd_pkg::C_CONT_BASE) begin
                        res.valid     = 1'b1;
                        res.code_unit = {8'h00, i_byte};
                    end else if (i_byte < utd_pkg::C_LEAD2_BASE) begin
                        res.valid = 1'b0;
                    end else if (i_byte < utd_pkg::C_LEAD4_BASE) begin
                        nxt.lead_byte  = i_byte;
                        nxt.held_count = utd_pkg::C_HELD_LEAD;
                    end else begin
                        nxt.skip_remaining = utd_pkg::long_skip(i_byte);
                        res.valid          = 1'b1;
                        res.code_unit      = utd_pkg::C_LONG_CODE;
                    end
                end
            endcase
        end
        if (i_eos) begin
            nxt.held_count     = utd_pkg::C_HELD_NONE;
            nxt.skip_remaining = 3'd0;
        end
    end

    assign o_state  = nxt;
    assign o_result = res;

endmodule
